/* hdl/lmss_pkg.sv */
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types and codes for the LED matrix scan and scroll core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmss_pkg;

    // Internal row and column counters are sized for the largest supported geometry.
    localparam int ROW_CNT_W  = 6;
    localparam int COL_CNT_W  = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SHIFT = 2'd1;
    localparam logic [1:0] KIND_SCAN  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b1;

    localparam logic [1:0] WR_FILL  = 2'd0;
    localparam logic [1:0] WR_SHIFT = 2'd1;
    localparam logic [1:0] WR_STAGE = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] row;
        logic [4:0] column;
        logic [7:0] pixel_byte;
        logic [3:0] shift_pixels;
        logic [3:0] row_start;
        logic [4:0] row_stop;
    } in_item_t;

    typedef struct packed {
        logic [7:0] column_byte;
        logic [3:0] row_address;
        logic       last_of_row;
    } out_item_t;

    typedef struct packed {
        logic                 item_load;
        logic [ROW_CNT_W-1:0] row;
        logic [COL_CNT_W-1:0] rd_col;
        logic                 wr_en;
        logic [COL_CNT_W-1:0] wr_col;
        logic [1:0]           wr_src;
        logic                 set_valid;
        logic                 clear_valid;
        logic                 out_load;
        logic                 out_last;
        logic                 scan_advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ROW_CNT_W-1:0] item_row;
        logic [4:0]           item_column;
        logic                 write_ok;
        logic [ROW_CNT_W-1:0] shift_start;
        logic [ROW_CNT_W-1:0] shift_stop;
        logic [ROW_CNT_W-1:0] scan_row;
        logic [4:0]           col_count;
        logic                 row_valid;
        logic                 out_free;
    } dp_status_t;

endpackage

/* hdl/led_matrix_scan_and_scroll_core.sv */
// ----------------------------------------------------------------------------
// led_matrix_scan_and_scroll_core
// Row-scan frame store with byte writes, band scrolling and scan output for
// a multiplexed 1-bit LED matrix.
//
// Items are handled one at a time through the single read and write port
// pair of the frame store RAM. A clear only drops the per-row valid bits. A
// write to a row already written since the last clear stores just the byte;
// a write to a blank row zero-fills the whole row as the byte goes in. A
// shift sweeps every column of each written row of the band and skips each
// blank row. A scan tick reads and sends one visible byte at a time, and
// waits while the output side stalls. Reset needs no clearing pass: rows
// read as zero until first written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_matrix_scan_and_scroll_core #(
    parameter int MAX_COLUMN_BYTES = 16,
    parameter int MAX_ROWS         = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lmss_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lmss_pkg::out_item_t               out_item,
    input  logic                              cfg_we,
    input  logic [lmss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmss_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lmss_pkg::ctrl_cmd_t  cmd;
    lmss_pkg::dp_status_t status;

    lmss_ctrl #(
        .MAX_COLUMN_BYTES (MAX_COLUMN_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lmss_datapath #(
        .MAX_COLUMN_BYTES (MAX_COLUMN_BYTES),
        .MAX_ROWS         (MAX_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

/* hdl/lmss_ram.sv */
// ----------------------------------------------------------------------------
// lmss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/lmss_ctrl.sv */
// ----------------------------------------------------------------------------
// lmss_ctrl
// Sequencer for the frame store: decodes each item and steps the datapath
// through row fills, shift sweeps and scan output, and clears the row valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmss_ctrl #(
    parameter int MAX_COLUMN_BYTES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lmss_pkg::dp_status_t status,
    output lmss_pkg::ctrl_cmd_t  cmd
);

    localparam int CW = lmss_pkg::COL_CNT_W;
    localparam int RW = lmss_pkg::ROW_CNT_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECODE   = 3'd1;
    localparam logic [2:0] ST_FILL     = 3'd2;
    localparam logic [2:0] ST_SHIFT    = 3'd3;
    localparam logic [2:0] ST_SCAN_RD  = 3'd4;
    localparam logic [2:0] ST_SCAN_OUT = 3'd5;

    localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_COLUMN_BYTES);

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] cb_ext;

    assign in_ready = (state_reg == ST_IDLE);
    assign cb_ext   = {2'b00, status.col_count};

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        cmd.row    = row_reg;
        cmd.rd_col = col_reg;
        cmd.wr_col = col_reg;
        cmd.wr_src = lmss_pkg::WR_FILL;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                col_next = '0;
                case (status.kind)
                    lmss_pkg::KIND_WRITE:
                    begin
                        row_next   = status.item_row;
                        state_next = status.write_ok ? ST_FILL : ST_IDLE;
                    end
                    lmss_pkg::KIND_SHIFT:
                    begin
                        row_next   = status.shift_start;
                        state_next = ST_SHIFT;
                    end
                    lmss_pkg::KIND_SCAN:
                    begin
                        row_next   = status.scan_row;
                        state_next = ST_SCAN_RD;
                    end
                    default:
                    begin
                        cmd.clear_valid = 1'b1;
                        state_next      = ST_IDLE;
                    end
                endcase
            end
            ST_FILL:
            begin
                // A row that was never written is zero-filled on its first write.
                cmd.wr_en = 1'b1;
                if (status.row_valid)
                begin
                    cmd.wr_col = {2'b00, status.item_column};
                    state_next = ST_IDLE;
                end
                else if (col_reg == LAST_SLOT)
                begin
                    cmd.set_valid = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            ST_SHIFT:
            begin
                if (row_reg >= status.shift_stop)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.row_valid)
                begin
                    row_next = row_reg + RW'(1);
                    col_next = '0;
                end
                else if (col_reg == cb_ext + CW'(2))
                begin
                    // The staging byte takes zeros from the right.
                    cmd.wr_en  = 1'b1;
                    cmd.wr_col = cb_ext;
                    cmd.wr_src = lmss_pkg::WR_STAGE;
                    row_next   = row_reg + RW'(1);
                    col_next   = '0;
                end
                else
                begin
                    // Writes trail reads by two columns, so each byte is
                    // rewritten only after its right neighbour has been read.
                    if (col_reg >= CW'(2))
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_col = col_reg - CW'(2);
                        cmd.wr_src = lmss_pkg::WR_SHIFT;
                    end
                    col_next = col_reg + CW'(1);
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_OUT;
            end
            ST_SCAN_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (col_reg == cb_ext - CW'(1))
                    begin
                        cmd.out_last     = 1'b1;
                        cmd.scan_advance = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + CW'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

endmodule

/* hdl/lmss_datapath.sv */
// ----------------------------------------------------------------------------
// lmss_datapath
// Frame store memory, row valid bits, configuration registers, scan row
// counter, shift unit and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmss_datapath #(
    parameter int MAX_COLUMN_BYTES = 16,
    parameter int MAX_ROWS         = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  lmss_pkg::in_item_t                      in_item,
    input  logic                                    cfg_we,
    input  logic [lmss_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lmss_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  lmss_pkg::ctrl_cmd_t                     cmd,
    output lmss_pkg::dp_status_t                    status,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output lmss_pkg::out_item_t                     out_item
);

    localparam int RW        = lmss_pkg::ROW_CNT_W;
    localparam int COL_W     = $clog2(MAX_COLUMN_BYTES + 1);
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int ROW_SLOTS = 1 << ROW_W;
    localparam int TOP_COLS  = (MAX_COLUMN_BYTES < 16) ? MAX_COLUMN_BYTES : 16;

    localparam logic [4:0]    TOP_COLS_V = 5'(TOP_COLS);
    localparam logic [RW-1:0] MAX_ROWS_V = RW'(MAX_ROWS);

    // Left shift by 0..8 pixels, filling from the top of the right neighbour.
    function automatic logic [7:0] shift_in(
        input logic [7:0] cur,
        input logic [7:0] nxt,
        input logic [3:0] p
    );
        logic [15:0] w;
        w = {cur, nxt} << p;
        return w[15:8];
    endfunction

    lmss_pkg::in_item_t  item_reg;
    lmss_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    logic [4:0]          cfg_cols_reg;
    logic [4:0]          cfg_rows_reg;
    logic [ROW_SLOTS-1:0] valid_reg;
    logic [ROW_W-1:0]    scan_row_reg;
    logic [7:0]          cur_reg;

    logic [4:0]       col_count;
    logic [RW-1:0]    row_limit;
    logic [RW-1:0]    stop_ext;
    logic [3:0]       p_sat;
    logic [ROW_W-1:0] row_idx;
    logic [RW-1:0]    scan_ext;
    logic [RW-1:0]    scan_inc;
    logic [7:0]       rd_data;
    logic [7:0]       wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic             row_valid;

    always_comb
    begin
        if (cfg_cols_reg == 5'd0)
        begin
            col_count = 5'd1;
        end
        else if (cfg_cols_reg > TOP_COLS_V)
        begin
            col_count = TOP_COLS_V;
        end
        else
        begin
            col_count = cfg_cols_reg;
        end

        if (cfg_rows_reg == 5'd0)
        begin
            row_limit = RW'(1);
        end
        else if ({1'b0, cfg_rows_reg} > MAX_ROWS_V)
        begin
            row_limit = MAX_ROWS_V;
        end
        else
        begin
            row_limit = {1'b0, cfg_rows_reg};
        end
    end

    assign stop_ext = ({1'b0, item_reg.row_stop} > row_limit) ? row_limit
                                                               : {1'b0, item_reg.row_stop};
    assign p_sat    = (item_reg.shift_pixels > 4'd8) ? 4'd8 : item_reg.shift_pixels;
    assign row_idx  = cmd.row[ROW_W-1:0];
    assign row_valid = valid_reg[row_idx];
    assign scan_ext = {{(RW - ROW_W){1'b0}}, scan_row_reg};
    assign scan_inc = scan_ext + RW'(1);
    assign rd_addr  = {row_idx, cmd.rd_col[COL_W-1:0]};
    assign wr_addr  = {row_idx, cmd.wr_col[COL_W-1:0]};

    always_comb
    begin
        case (cmd.wr_src)
            lmss_pkg::WR_FILL:
            begin
                wr_data = (cmd.wr_col == {2'b00, item_reg.column}) ? item_reg.pixel_byte
                                                                  : 8'h00;
            end
            lmss_pkg::WR_SHIFT:
            begin
                wr_data = shift_in(cur_reg, rd_data, p_sat);
            end
            lmss_pkg::WR_STAGE:
            begin
                wr_data = shift_in(cur_reg, 8'h00, p_sat);
            end
            default:
            begin
                wr_data = 8'h00;
            end
        endcase
    end

    lmss_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        status.kind        = item_reg.kind;
        status.item_row    = {2'b00, item_reg.row};
        status.item_column = item_reg.column;
        status.write_ok    = ({2'b00, item_reg.row} < MAX_ROWS_V)
                             && (item_reg.column <= col_count);
        status.shift_start = {2'b00, item_reg.row_start};
        status.shift_stop  = stop_ext;
        status.scan_row    = scan_ext;
        status.col_count   = col_count;
        status.row_valid   = row_valid;
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= rd_data;
        if (cmd.item_load)
        begin
            item_reg <= in_item;
        end
        if (cmd.out_load)
        begin
            // Rows never written since the last clear read as blank.
            out_reg.column_byte <= row_valid ? rd_data : 8'h00;
            out_reg.row_address <= scan_ext[3:0];
            out_reg.last_of_row <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cfg_cols_reg  <= 5'd8;
            cfg_rows_reg  <= 5'd16;
            valid_reg     <= '0;
            scan_row_reg  <= '0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    lmss_pkg::CFG_COLUMN_BYTES: cfg_cols_reg <= cfg_data;
                    lmss_pkg::CFG_ROW_COUNT:    cfg_rows_reg <= cfg_data;
                    default:                    cfg_cols_reg <= cfg_cols_reg;
                endcase
            end

            if (cmd.clear_valid)
            begin
                valid_reg <= '0;
            end
            else if (cmd.set_valid)
            begin
                valid_reg[row_idx] <= 1'b1;
            end

            if (cmd.scan_advance)
            begin
                scan_row_reg <= (scan_inc >= row_limit) ? '0 : scan_inc[ROW_W-1:0];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* tb/tb_led_matrix_scan_and_scroll_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_scan_and_scroll_core
// Self-checking bench for the LED matrix frame store. It runs a short table
// of directed items, then random writes, scrolls, scan ticks and clears
// under several row and column geometries. A local copy of the frame store
// predicts every scanned byte, and each output item is compared in order.
// ----------------------------------------------------------------------------

module tb_led_matrix_scan_and_scroll_core;

    localparam int ROWS           = 16;
    localparam int COLS           = 16;
    localparam int SETTLE_CYCLES  = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int RAND_PER_PHASE = 26;
    localparam int PHASES         = 6;

    typedef struct {
        lmss_pkg::in_item_t item;
        bit                 typed;
        logic [7:0]         exp_byte;
        logic [3:0]         exp_row;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    lmss_pkg::in_item_t              in_item;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    lmss_pkg::out_item_t             out_item;
    logic                            cfg_we;
    logic [lmss_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lmss_pkg::CFG_DATA_W-1:0] cfg_data;

    // Local copy of the frame store, scan pointer and geometry registers.
    logic [7:0]          frame_mem [ROWS][COLS+1];
    int                  scan_ptr;
    logic [4:0]          cols_reg;
    logic [4:0]          rows_reg;
    lmss_pkg::out_item_t pending_bytes[$];
    dir_row_t            dir_tab[$];
    int                  errors = 0;
    int                  quiet_cycles = 0;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    led_matrix_scan_and_scroll_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int visible_cols();
        int c;
        c = cols_reg;
        if (c < 1) c = 1;
        if (c > COLS) c = COLS;
        return c;
    endfunction

    function automatic logic [7:0] scroll_byte(logic [7:0] cur, logic [7:0] nxt, int p);
        logic [15:0] pair;
        pair = {cur, nxt} << p;
        return pair[15:8];
    endfunction

    function automatic void predict_frame_item(lmss_pkg::in_item_t it);
        int                  cb;
        int                  rc;
        int                  p;
        int                  stop;
        lmss_pkg::out_item_t o;
        cb = visible_cols();
        rc = rows_reg;
        if (rc < 1) rc = 1;
        if (rc > ROWS) rc = ROWS;
        case (it.kind)
            lmss_pkg::KIND_WRITE:
            begin
                if (it.column <= cb) frame_mem[it.row][it.column] = it.pixel_byte;
            end
            lmss_pkg::KIND_SHIFT:
            begin
                p    = (it.shift_pixels > 8) ? 8 : it.shift_pixels;
                stop = (it.row_stop > rc) ? rc : it.row_stop;
                // Left to right, so each byte still sees its old right neighbour.
                for (int r = it.row_start; r < stop; r++)
                begin
                    for (int c = 0; c < cb; c++)
                        frame_mem[4'(r)][5'(c)] = scroll_byte(frame_mem[4'(r)][5'(c)],
                                                              frame_mem[4'(r)][5'(c + 1)], p);
                    frame_mem[4'(r)][5'(cb)] = scroll_byte(frame_mem[4'(r)][5'(cb)], 8'h00, p);
                end
            end
            lmss_pkg::KIND_SCAN:
            begin
                for (int c = 0; c < cb; c++)
                begin
                    o.column_byte = frame_mem[4'(scan_ptr)][5'(c)];
                    o.row_address = scan_ptr[3:0];
                    o.last_of_row = (c == cb - 1);
                    pending_bytes.push_back(o);
                end
                scan_ptr = (scan_ptr + 1 >= rc) ? 0 : scan_ptr + 1;
            end
            default:
            begin
                foreach (frame_mem[r, c]) frame_mem[r][c] = 8'h00;
            end
        endcase
    endfunction

    function automatic lmss_pkg::in_item_t pack_item(logic [1:0] kind, int row, int column,
                                                     int pix, int shift, int start, int stop);
        lmss_pkg::in_item_t it;
        it.kind         = kind;
        it.row          = 4'(row);
        it.column       = 5'(column);
        it.pixel_byte   = 8'(pix);
        it.shift_pixels = 4'(shift);
        it.row_start    = 4'(start);
        it.row_stop     = 5'(stop);
        return it;
    endfunction

    function automatic void add_dir(logic [1:0] kind, int row, int column, int pix, int shift,
                                    int start, int stop, bit typed = 1'b0,
                                    logic [7:0] b = 8'h00, logic [3:0] r = 4'd0);
        dir_row_t d;
        d.item     = pack_item(kind, row, column, pix, shift, start, stop);
        d.typed    = typed;
        d.exp_byte = b;
        d.exp_row  = r;
        dir_tab.push_back(d);
    endfunction

    function automatic lmss_pkg::in_item_t random_item();
        lmss_pkg::in_item_t it;
        int                 pick;
        it   = lmss_pkg::in_item_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            it.kind = lmss_pkg::KIND_WRITE;
            if ($urandom_range(0, 9) != 0) it.column = 5'($urandom_range(0, visible_cols()));
        end
        else if (pick < 65)
        begin
            it.kind = lmss_pkg::KIND_SHIFT;
            if ($urandom_range(0, 4) != 0) it.shift_pixels = 4'($urandom_range(0, 8));
            if ($urandom_range(0, 3) != 0) it.row_stop = 5'($urandom_range(it.row_start, 16));
        end
        else if (pick < 97)
        begin
            it.kind = lmss_pkg::KIND_SCAN;
        end
        else
        begin
            it.kind = lmss_pkg::KIND_CLEAR;
        end
        return it;
    endfunction

    // Where typed is set, the scanned bytes and row are the ones given by hand.
    task automatic send_item(lmss_pkg::in_item_t it, bit typed = 1'b0, logic [7:0] b = 8'h00,
                             logic [3:0] r = 4'd0);
        int first;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        first = pending_bytes.size();
        predict_frame_item(it);
        if (typed)
        begin
            for (int i = first; i < pending_bytes.size(); i++)
            begin
                pending_bytes[i].column_byte = b;
                pending_bytes[i].row_address = r;
            end
        end
    endtask

    // A write or shift leaves no output behind, so give the longest one time to finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(logic [4:0] cols, logic [4:0] rows);
        cfg_we    <= 1'b1;
        cfg_index <= lmss_pkg::CFG_COLUMN_BYTES;
        cfg_data  <= cols;
        @(posedge clk);
        cols_reg = cols;
        cfg_index <= lmss_pkg::CFG_ROW_COUNT;
        cfg_data  <= rows;
        @(posedge clk);
        rows_reg = rows;
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        lmss_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_item.column_byte !== want.column_byte)
                begin
                    $display("%0t: column_byte expected %h actual %h",
                             $time, want.column_byte, out_item.column_byte);
                    errors++;
                end
                if (out_item.row_address !== want.row_address)
                begin
                    $display("%0t: row_address expected %h actual %h",
                             $time, want.row_address, out_item.row_address);
                    errors++;
                end
                if (out_item.last_of_row !== want.last_of_row)
                begin
                    $display("%0t: last_of_row expected %b actual %b",
                             $time, want.last_of_row, out_item.last_of_row);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 7;
        recv_stall_pct = 74;
        foreach (frame_mem[r, c]) frame_mem[r][c] = 8'h00;
        scan_ptr = 0;
        cols_reg = 5'd8;
        rows_reg = 5'd16;

        // Directed items under the reset geometry of 8 bytes by 16 rows.
        add_dir(lmss_pkg::KIND_SCAN,  0,  0,     0,  0,  0,  0, 1'b1, 8'h00, 4'd0);
        add_dir(lmss_pkg::KIND_WRITE, 1,  0, 8'hFF,  0,  0,  0);
        add_dir(lmss_pkg::KIND_WRITE, 1,  7, 8'h81,  0,  0,  0);
        add_dir(lmss_pkg::KIND_WRITE, 1,  8, 8'hA5,  0,  0,  0);
        add_dir(lmss_pkg::KIND_WRITE, 1,  9, 8'h3C,  0,  0,  0);
        add_dir(lmss_pkg::KIND_WRITE, 1, 31, 8'h55,  0,  0,  0);
        add_dir(lmss_pkg::KIND_WRITE, 15, 0, 8'h80,  0,  0,  0);
        add_dir(lmss_pkg::KIND_WRITE, 15, 8, 8'h01,  0,  0,  0);
        add_dir(lmss_pkg::KIND_SHIFT, 0,  0,     0,  3,  1,  2);
        add_dir(lmss_pkg::KIND_SHIFT, 0,  0,     0, 12,  1,  2);
        add_dir(lmss_pkg::KIND_SHIFT, 0,  0,     0,  0,  0, 16);
        add_dir(lmss_pkg::KIND_SHIFT, 0,  0,     0, 15, 15, 31);
        add_dir(lmss_pkg::KIND_SHIFT, 0,  0,     0,  2,  5,  2);
        add_dir(lmss_pkg::KIND_SHIFT, 0,  0,     0,  1,  0,  0);
        add_dir(lmss_pkg::KIND_SCAN,  0,  0,     0,  0,  0,  0);
        add_dir(lmss_pkg::KIND_WRITE, 2,  3, 8'h7E,  0,  0,  0);
        add_dir(lmss_pkg::KIND_SCAN,  0,  0,     0,  0,  0,  0);
        add_dir(lmss_pkg::KIND_CLEAR, 0,  0,     0,  0,  0,  0);
        add_dir(lmss_pkg::KIND_SCAN,  0,  0,     0,  0,  0,  0, 1'b1, 8'h00, 4'd3);
        add_dir(lmss_pkg::KIND_WRITE, 4,  8, 8'hC3,  0,  0,  0);
        add_dir(lmss_pkg::KIND_SHIFT, 0,  0,     0,  8,  4,  5);
        add_dir(lmss_pkg::KIND_SCAN,  0,  0,     0,  0,  0,  0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].exp_byte,
                      dir_tab[i].exp_row);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                case (ph)
                    1: set_geometry(5'd1, 5'd1);
                    2: set_geometry(5'd16, 5'd16);
                    3: set_geometry(5'd0, 5'd3);
                    4: set_geometry(5'd31, 5'd0);
                    default: set_geometry(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
                endcase
            end
            if (ph < 2)
            begin
                send_idle_pct  = 7;
                recv_stall_pct = 74;
            end
            else if (ph < 4)
            begin
                send_idle_pct  = 74;
                recv_stall_pct = 7;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_item(random_item());
            // Park the scan row past the next row count, so the wrap after a shrink is hit.
            if (ph == 2)
                while (scan_ptr < 8)
                    send_item(pack_item(lmss_pkg::KIND_SCAN, 0, 0, 0, 0, 0, 0));
        end

        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/lmss_pkg.sv
hdl/lmss_ram.sv
hdl/lmss_ctrl.sv
hdl/lmss_datapath.sv
hdl/led_matrix_scan_and_scroll_core.sv
tb/tb_led_matrix_scan_and_scroll_core.sv
